[src/rau_pkg.sv]
package rau_pkg;

  // Field width of every numerator and denominator
  localparam int WIDTH = 32;
  localparam int PW    = 2 * WIDTH;      // exact product width
  localparam int XW    = 2 * WIDTH + 1;  // exact sum width
  localparam int CNT_W = $clog2(WIDTH);
  localparam int K_W   = $clog2(WIDTH + 1);

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_RED = 4'd4,
    OP_LT  = 4'd5,
    OP_GT  = 4'd6,
    OP_EQ  = 4'd7,
    OP_NE  = 4'd8,
    OP_NEG = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_GCD,
    S_DIVX,
    S_DIVY,
    S_FIN
  } state_e;

  // True when an exact value fits a WIDTH-bit signed field
  function automatic logic fits(input logic signed [XW-1:0] v);
    return (&v[XW-1:WIDTH-1]) | ~(|v[XW-1:WIDTH-1]);
  endfunction

endpackage

[src/rau_in_if.sv]
interface rau_in_if;
  logic                              valid;
  logic                              ready;
  logic [3:0]                        opcode;
  logic signed [rau_pkg::WIDTH-1:0]  a_num;
  logic signed [rau_pkg::WIDTH-1:0]  a_den;
  logic signed [rau_pkg::WIDTH-1:0]  b_num;
  logic signed [rau_pkg::WIDTH-1:0]  b_den;

  modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

[src/rau_out_if.sv]
interface rau_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rau_pkg::WIDTH-1:0]  res_num;
  logic signed [rau_pkg::WIDTH-1:0]  res_den;
  logic                              compare_true;
  logic                              overflow;
  logic                              zero_den;

  modport source (output valid, res_num, res_den, compare_true, overflow, zero_den,
                  input ready);
  modport sink   (input valid, res_num, res_den, compare_true, overflow, zero_den,
                  output ready);
endinterface

[src/rational_arithmetic_unit.sv]
// Sequence after an input transfer: negate and unused opcodes go straight to the finish
//   state; mul, div and compares form their products in the shared multiplier, add and sub also
//   that of the denominators; reduce runs the binary gcd loop, then divides both by the gcd.
// Throughput: one item at a time; the next input transfer can follow in the cycle after the
//   result is registered, and a result held by the receiver stalls the input.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle, no result pending.
module rational_arithmetic_unit (
  input  logic    clk_i,
  input  logic    rst_ni,
  rau_in_if.sink  in_i,
  rau_out_if.source out_o
);
  import rau_pkg::*;

  state_e state_q, state_d;

  logic [3:0]              op_q;
  logic signed [WIDTH-1:0] ax_q, ay_q, bx_q, by_q;
  logic                    ov_q;
  logic [1:0]              step_q;
  logic signed [PW-1:0]    prod_q [3];
  logic [WIDTH-1:0]        u_q, v_q, g_q, rem_q, dq_q, qx_q;
  logic [K_W-1:0]          k_q;
  logic [CNT_W-1:0]        cnt_q;

  logic                    out_valid_q;
  logic signed [WIDTH-1:0] res_num_q, res_den_q;
  logic                    cmp_q, ovo_q, zd_q;

  // Input normalization: move the denominator sign into the numerator
  logic signed [WIDTH-1:0] nax, nay, nbx, nby;
  logic                    nov;
  localparam logic signed [WIDTH-1:0] MINV = {1'b1, {(WIDTH-1){1'b0}}};

  always_comb begin
    nax = in_i.a_num;
    nay = in_i.a_den;
    nbx = in_i.b_num;
    nby = in_i.b_den;
    nov = 1'b0;
    if (in_i.a_den[WIDTH-1]) begin
      nov = nov | (in_i.a_num == MINV) | (in_i.a_den == MINV);
      nax = -in_i.a_num;
      nay = -in_i.a_den;
    end
    if (in_i.b_den[WIDTH-1]) begin
      nov = nov | (in_i.b_num == MINV) | (in_i.b_den == MINV);
      nbx = -in_i.b_num;
      nby = -in_i.b_den;
    end
  end

  logic in_xfer, out_xfer, fin_go;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid & in_i.ready;
  assign out_xfer   = out_valid_q & out_o.ready;
  assign fin_go     = (state_q == S_FIN) & (~out_valid_q | out_o.ready);

  // Shared multiplier, one signed product per cycle
  logic signed [WIDTH-1:0] mul_a, mul_b;
  logic signed [PW-1:0]    mul_p;
  logic [1:0]              last_step;

  always_comb begin
    mul_a = ax_q;
    mul_b = by_q;
    unique case (step_q)
      2'd0: begin
        mul_a = ax_q;
        mul_b = (op_q == OP_MUL) ? bx_q : by_q;
      end
      2'd1: begin
        mul_a = ay_q;
        mul_b = (op_q == OP_MUL) ? by_q : bx_q;
      end
      default: begin
        mul_a = ay_q;
        mul_b = by_q;
      end
    endcase
  end
  assign mul_p     = mul_a * mul_b;
  assign last_step = (op_q == OP_ADD || op_q == OP_SUB) ? 2'd2 : 2'd1;

  // Shared subtractor for the gcd loop and the restoring divider
  logic [WIDTH:0]   sub_a, sub_b, rem_sh;
  logic [WIDTH+1:0] diff;
  logic             borrow;
  logic [WIDTH-1:0] uv_or, g_new, mx, my;

  assign rem_sh = {rem_q, dq_q[WIDTH-1]};
  always_comb begin
    if (state_q == S_GCD) begin
      sub_a = {1'b0, u_q};
      sub_b = {1'b0, v_q};
    end else begin
      sub_a = rem_sh;
      sub_b = {1'b0, g_q};
    end
  end
  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow = diff[WIDTH+1];
  assign uv_or  = u_q | v_q;
  assign g_new  = uv_or << k_q;
  assign mx     = ax_q[WIDTH-1] ? -ax_q : ax_q;
  assign my     = ay_q[WIDTH-1] ? -ay_q : ay_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_i.opcode)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV,
            OP_LT, OP_GT, OP_EQ, OP_NE: state_d = S_MUL;
            OP_RED:                     state_d = S_GCD;
            default:                    state_d = S_FIN;
          endcase
        end
      end
      S_MUL:  if (step_q == last_step) state_d = S_FIN;
      S_GCD: begin
        if (u_q == '0 || v_q == '0) state_d = (g_new == '0) ? S_FIN : S_DIVX;
      end
      S_DIVX: if (cnt_q == '0) state_d = S_DIVY;
      S_DIVY: if (cnt_q == '0) state_d = S_FIN;
      S_FIN:  if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Result assembly from the stored products and quotients
  logic signed [XW-1:0]    p0, p1, p2, qv, nsum, ndiv, ddiv;
  logic signed [WIDTH-1:0] r_num, r_den;
  logic                    r_cmp, r_ov, r_zd;
  logic [WIDTH-1:0]        qx_s, qy_s;

  assign p0   = XW'(prod_q[0]);
  assign p1   = XW'(prod_q[1]);
  assign p2   = XW'(prod_q[2]);
  assign qv   = (op_q == OP_SUB) ? -p1 : p1;
  assign nsum = p0 + qv;
  assign ndiv = prod_q[1][PW-1] ? -p0 : p0;
  assign ddiv = prod_q[1][PW-1] ? -p1 : p1;
  assign qx_s = ax_q[WIDTH-1] ? -qx_q : qx_q;
  assign qy_s = ay_q[WIDTH-1] ? -dq_q : dq_q;

  always_comb begin
    r_num = '0;
    r_den = '0;
    r_cmp = 1'b0;
    r_ov  = ov_q;
    r_zd  = 1'b0;
    unique case (op_q)
      OP_ADD, OP_SUB: begin
        r_ov  = ov_q | ~fits(p0) | ~fits(qv) | ~fits(nsum) | ~fits(p2);
        r_num = nsum[WIDTH-1:0];
        r_den = p2[WIDTH-1:0];
      end
      OP_MUL: begin
        r_ov  = ov_q | ~fits(p0) | ~fits(p1);
        r_num = p0[WIDTH-1:0];
        r_den = p1[WIDTH-1:0];
      end
      OP_DIV: begin
        r_ov  = ov_q | ~fits(ndiv) | ~fits(ddiv);
        r_num = ndiv[WIDTH-1:0];
        r_den = ddiv[WIDTH-1:0];
      end
      OP_RED: begin
        if (g_q != '0) begin
          r_num = qx_s;
          r_den = qy_s;
        end
      end
      OP_LT:  r_cmp = prod_q[0] <  prod_q[1];
      OP_GT:  r_cmp = prod_q[0] >  prod_q[1];
      OP_EQ:  r_cmp = prod_q[0] == prod_q[1];
      OP_NE:  r_cmp = prod_q[0] != prod_q[1];
      OP_NEG: begin
        r_ov  = ov_q | (ax_q == MINV);
        r_num = -ax_q;
        r_den = ay_q;
      end
      default: r_ov = 1'b0;
    endcase
    priority if (op_q == OP_LT || op_q == OP_GT || op_q == OP_EQ || op_q == OP_NE) begin
      r_zd = (ay_q == '0) | (by_q == '0);
    end else if (op_q == OP_RED && g_q == '0) begin
      r_zd = 1'b1;
    end else if (op_q <= OP_NEG) begin
      r_zd = (r_den == '0);
    end else begin
      r_zd = 1'b0;
    end
  end

  // Sequencer state and valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_go)        out_valid_q <= 1'b1;
      else if (out_xfer) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_q   <= in_i.opcode;
          ax_q   <= nax;
          ay_q   <= nay;
          bx_q   <= nbx;
          by_q   <= nby;
          ov_q   <= nov;
          step_q <= '0;
          k_q    <= '0;
          u_q    <= nax[WIDTH-1] ? -nax : nax;
          v_q    <= nay[WIDTH-1] ? -nay : nay;
        end
      end
      S_MUL: begin
        prod_q[step_q] <= mul_p;
        step_q         <= step_q + 2'd1;
      end
      S_GCD: begin
        if (u_q == '0 || v_q == '0) begin
          g_q   <= g_new;
          rem_q <= '0;
          dq_q  <= mx;
          cnt_q <= CNT_W'(WIDTH - 1);
        end else if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + K_W'(1);
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (!borrow) begin
          u_q <= diff[WIDTH-1:0];
        end else begin
          v_q <= -diff[WIDTH-1:0];
        end
      end
      S_DIVX, S_DIVY: begin
        if (cnt_q == '0 && state_q == S_DIVX) begin
          // Numerator quotient done, start on the denominator
          qx_q  <= {dq_q[WIDTH-2:0], ~borrow};
          dq_q  <= my;
          rem_q <= '0;
          cnt_q <= CNT_W'(WIDTH - 1);
        end else begin
          rem_q <= borrow ? rem_sh[WIDTH-1:0] : diff[WIDTH-1:0];
          dq_q  <= {dq_q[WIDTH-2:0], ~borrow};
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
      S_FIN: begin
        if (fin_go) begin
          res_num_q <= r_num;
          res_den_q <= r_den;
          cmp_q     <= r_cmp;
          ovo_q     <= r_ov;
          zd_q      <= r_zd;
        end
      end
      default: ;
    endcase
  end

  // Output channel
  assign out_o.valid        = out_valid_q;
  assign out_o.res_num      = res_num_q;
  assign out_o.res_den      = res_den_q;
  assign out_o.compare_true = cmp_q;
  assign out_o.overflow     = ovo_q;
  assign out_o.zero_den     = zd_q;

endmodule

[src/rau_checker.sv]
module rau_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic signed [rau_pkg::WIDTH-1:0] res_num_i,
  input logic signed [rau_pkg::WIDTH-1:0] res_den_i,
  input logic                             compare_true_i
);
  import rau_pkg::*;

  // A pending result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(res_num_i) && $stable(res_den_i))
    else $error("result changed while stalled");

  // One item at a time: busy right after an input transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready high right after input transfer");

  // A compare result carries a zero fraction
  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && compare_true_i |-> res_num_i == '0 && res_den_i == '0)
    else $error("compare result with nonzero fraction");

  // No result can appear on the cycle right after an input transfer
  a_min_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result too early");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .res_num_i      (out_o.res_num),
  .res_den_i      (out_o.res_den),
  .compare_true_i (out_o.compare_true)
);
